/* rtl/ptt_pkg.sv */
package ptt_pkg;

  localparam int unsigned DEFAULT_SLOTS = 16;
  localparam int unsigned MAX_FIRES = 16;
  localparam int unsigned FIRE_CNT_W = $clog2(MAX_FIRES + 1);
  localparam logic [31:0] DUE_BIAS = 32'h8000_0000;

  typedef enum logic [1:0] {
    FN_TICK    = 2'd0,
    FN_ADD     = 2'd1,
    FN_DEL     = 2'd2,
    FN_DEL_ALL = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_FIRED = 2'd0,
    ST_DONE  = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  key;
    logic [31:0] expiry;
    logic [15:0] period;
  } entry_t;

  typedef struct packed {
    logic best_found;
    logic match_found;
    logic free_found;
  } scan_flags_t;

endpackage

/* rtl/ptt_mem.sv */
module ptt_mem #(
  parameter int unsigned SLOTS = ptt_pkg::DEFAULT_SLOTS,
  localparam int unsigned IDXW = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDXW-1:0]  waddr,
  input  ptt_pkg::entry_t  wdata,
  input  logic [IDXW-1:0]  raddr,
  output ptt_pkg::entry_t  rdata
);
  import ptt_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ptt_scan.sv */
module ptt_scan #(
  parameter int unsigned SLOTS = ptt_pkg::DEFAULT_SLOTS,
  localparam int unsigned IDXW = $clog2(SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 live,
  input  logic                 tick_mode,
  input  logic [IDXW-1:0]      slot,
  input  ptt_pkg::entry_t      entry,
  input  logic                 entry_valid,
  input  logic                 entry_done,
  input  logic [31:0]          now,
  input  logic [7:0]           cmd_id,
  output ptt_pkg::scan_flags_t flags,
  output ptt_pkg::entry_t      best,
  output logic [IDXW-1:0]      best_slot,
  output logic [IDXW-1:0]      match_slot,
  output logic [IDXW-1:0]      free_slot
);
  import ptt_pkg::*;

  logic [31:0] best_age;
  logic [31:0] age;
  logic        due;
  logic        better;
  logic        take_best;
  logic        take_match;
  logic        take_free;

  // wrap-safe age: due timers land at or above DUE_BIAS, older is smaller
  assign age = (entry.expiry - now) ^ DUE_BIAS;
  assign due = age[31];
  assign better = !flags.best_found || (age < best_age) ||
                  ((age == best_age) && (entry.key < best.key));

  assign take_best  = live && tick_mode && entry_valid && !entry_done && due && better;
  assign take_match = live && !tick_mode && entry_valid && (entry.key == cmd_id) &&
                      !flags.match_found;
  assign take_free  = live && !tick_mode && !entry_valid && !flags.free_found;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flags <= '0;
    end else begin
      if (take_best) begin
        flags.best_found <= 1'b1;
        best             <= entry;
        best_age         <= age;
        best_slot        <= slot;
      end
      if (take_match) begin
        flags.match_found <= 1'b1;
        match_slot        <= slot;
      end
      if (take_free) begin
        flags.free_found <= 1'b1;
        free_slot        <= slot;
      end
    end
  end

endmodule

/* rtl/periodic_timer_table.sv */
// Table of TIMER_SLOTS timers keyed by an 8-bit id, with a 32-bit tick counter.
// One item is taken at a time; in_ready is high only while the block is idle,
// and a finished result may still sit in the output register meanwhile.
// Every item except delete-all walks the slot memory one slot per cycle
// through its single read port. Add, modify and delete take one pass;
// delete-all skips the scan. A tick that fires F timers takes F + 1 passes,
// or 16 passes when 16 fire. Each pass picks the oldest due timer (ties:
// lower id); results are held one pass so the final one carries last. At
// most 16 timers fire per tick. Output stalls add cycles.
module periodic_timer_table #(
  parameter int unsigned TIMER_SLOTS = ptt_pkg::DEFAULT_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  timer_id,
  input  logic [15:0] start_delay,
  input  logic [15:0] expire_delay,
  input  logic [15:0] reload_period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  fired_id,
  output logic        last
);
  import ptt_pkg::*;

  localparam int unsigned IDXW = $clog2(TIMER_SLOTS);
  localparam int unsigned CNTW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CNTW-1:0] SCAN_END = CNTW'(TIMER_SLOTS);
  localparam logic [FIRE_CNT_W-1:0] FIRE_LAST = FIRE_CNT_W'(MAX_FIRES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FLUSH
  } state_t;

  state_t                 state;
  logic [31:0]            now_time;
  logic [TIMER_SLOTS-1:0] slot_valid;
  logic [TIMER_SLOTS-1:0] done;
  logic [CNTW-1:0]        scan_idx;
  logic                   q_live;
  logic [IDXW-1:0]        q_idx;
  func_t                  cmd_func;
  logic [7:0]             cmd_id;
  logic [16:0]            cmd_delay;
  logic [15:0]            cmd_period;
  logic [FIRE_CNT_W-1:0]  fire_cnt;
  logic                   pend_valid;
  logic [7:0]             pend_key;

  logic            in_fire;
  logic            out_free;
  logic            scan_clear;
  logic            rescan;
  logic            fire_go;
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic [IDXW-1:0] mem_raddr;
  entry_t          mem_rdata;
  scan_flags_t     flags;
  entry_t          best;
  logic [IDXW-1:0] best_slot;
  logic [IDXW-1:0] match_slot;
  logic [IDXW-1:0] free_slot;
  logic [IDXW-1:0] add_slot;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign add_slot = flags.match_found ? match_slot : free_slot;

  assign fire_go    = (state == S_DECIDE) && (cmd_func == FN_TICK) && flags.best_found &&
                      (!pend_valid || out_free);
  assign rescan     = fire_go && (fire_cnt != FIRE_LAST);
  assign scan_clear = in_fire || rescan;
  assign mem_raddr  = (scan_idx < SCAN_END) ? scan_idx[IDXW-1:0] : '0;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_slot;
    mem_wdata = best;
    mem_wdata.expiry = best.expiry + 32'(best.period);
    if (fire_go && (best.period != '0)) begin
      mem_we = 1'b1;
    end else if ((state == S_DECIDE) && (cmd_func == FN_ADD) && out_free &&
                 (flags.match_found || flags.free_found)) begin
      mem_we           = 1'b1;
      mem_waddr        = add_slot;
      mem_wdata.key    = cmd_id;
      mem_wdata.expiry = now_time + 32'(cmd_delay);
      mem_wdata.period = cmd_period;
    end
  end

  ptt_mem #(.SLOTS(TIMER_SLOTS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ptt_scan #(.SLOTS(TIMER_SLOTS)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .clear       (scan_clear),
    .live        (q_live),
    .tick_mode   (cmd_func == FN_TICK),
    .slot        (q_idx),
    .entry       (mem_rdata),
    .entry_valid (slot_valid[q_idx]),
    .entry_done  (done[q_idx]),
    .now         (now_time),
    .cmd_id      (cmd_id),
    .flags       (flags),
    .best        (best),
    .best_slot   (best_slot),
    .match_slot  (match_slot),
    .free_slot   (free_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now_time   <= '0;
      slot_valid <= '0;
      done       <= '0;
      scan_idx   <= '0;
      q_live     <= 1'b0;
      cmd_func   <= FN_TICK;
      fire_cnt   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      q_live <= (state == S_SCAN) && (scan_idx < SCAN_END);
      q_idx  <= scan_idx[IDXW-1:0];

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            cmd_func   <= func_t'(func);
            cmd_id     <= timer_id;
            cmd_delay  <= 17'(start_delay) + 17'(expire_delay);
            cmd_period <= reload_period;
            scan_idx   <= '0;
            if (func_t'(func) == FN_TICK) begin
              now_time   <= now_time + 32'd1;
              done       <= '0;
              fire_cnt   <= '0;
              pend_valid <= 1'b0;
            end
            state <= (func_t'(func) == FN_DEL_ALL) ? S_DECIDE : S_SCAN;
          end
        end

        S_SCAN: begin
          if (scan_idx < SCAN_END) begin
            scan_idx <= scan_idx + CNTW'(1);
          end else begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (cmd_func == FN_TICK) begin
            if (flags.best_found) begin
              if (fire_go) begin
                if (pend_valid) begin
                  out_valid <= 1'b1;
                  status    <= ST_FIRED;
                  fired_id  <= pend_key;
                  last      <= 1'b0;
                end
                pend_valid       <= 1'b1;
                pend_key         <= best.key;
                done[best_slot]  <= 1'b1;
                if (best.period == '0) begin
                  slot_valid[best_slot] <= 1'b0;
                end
                fire_cnt <= fire_cnt + FIRE_CNT_W'(1);
                scan_idx <= '0;
                state    <= rescan ? S_SCAN : S_FLUSH;
              end
            end else if (!pend_valid) begin
              state <= S_IDLE;
            end else if (out_free) begin
              out_valid  <= 1'b1;
              status     <= ST_FIRED;
              fired_id   <= pend_key;
              last       <= 1'b1;
              pend_valid <= 1'b0;
              state      <= S_IDLE;
            end
          end else if (out_free) begin
            out_valid <= 1'b1;
            last      <= 1'b1;
            status    <= ST_DONE;
            fired_id  <= cmd_id;
            case (cmd_func)
              FN_ADD: begin
                if (flags.match_found || flags.free_found) begin
                  slot_valid[add_slot] <= 1'b1;
                end else begin
                  status <= ST_FULL;
                end
              end
              FN_DEL: begin
                if (flags.match_found) begin
                  slot_valid[match_slot] <= 1'b0;
                end
              end
              default: begin
                slot_valid <= '0;
                fired_id   <= '0;
              end
            endcase
            state <= S_IDLE;
          end
        end

        S_FLUSH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= ST_FIRED;
            fired_id   <= pend_key;
            last       <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cmd_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && cmd_func != FN_TICK && out_free)
      |=> (state == S_IDLE && out_valid && last))
    else $error("command result not issued");

  a_tick_time: assert property (@(posedge clk) disable iff (rst)
    (in_fire && func_t'(func) == FN_TICK) |=> (now_time == $past(now_time) + 32'd1))
    else $error("tick did not advance time");

  a_pick_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && cmd_func == FN_TICK && flags.best_found)
      |-> (slot_valid[best_slot] && !done[best_slot]))
    else $error("picked timer is stale or already fired");

  a_pend_tick: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (cmd_func == FN_TICK && state != S_IDLE))
    else $error("pending fire outside a tick");

  a_live_scan: assert property (@(posedge clk) disable iff (rst)
    q_live |-> (state == S_SCAN))
    else $error("read data live outside scan");

endmodule

/* dv/periodic_timer_table_tb.sv */
`timescale 1ns / 1ps

module periodic_timer_table_tb;
  import ptt_pkg::*;

  localparam int SLOTS = DEFAULT_SLOTS;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  typedef struct {
    func_t       fn;
    logic [7:0]  id;
    logic [15:0] sd;
    logic [15:0] ed;
    logic [15:0] rp;
    bit          sync;
  } cmd_t;

  typedef struct {
    status_t    st;
    logic [7:0] id;
    logic       last;
  } note_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [7:0]  timer_id = '0;
  logic [15:0] start_delay = '0;
  logic [15:0] expire_delay = '0;
  logic [15:0] reload_period = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  fired_id;
  logic        last;

  cmd_t  cmd_q[$];
  note_t want_q[$];

  // timer table as predicted
  bit        slot_on  [SLOTS];
  bit [7:0]  slot_id  [SLOTS];
  bit [31:0] slot_due [SLOTS];
  bit [15:0] slot_per [SLOTS];
  bit [31:0] tick_now = '0;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   tx_wait = 0;
  int   rx_wait = 0;
  int   acc_n = 0;
  int   got_n = 0;
  int   fails = 0;
  int   idle_cycles = 0;

  always #2 clk = ~clk;

  periodic_timer_table DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .timer_id(timer_id),
    .start_delay(start_delay),
    .expire_delay(expire_delay),
    .reload_period(reload_period),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .fired_id(fired_id),
    .last(last)
  );

  task automatic queue_cmd(input func_t fn, input logic [7:0] id, input logic [15:0] sd,
                           input logic [15:0] ed, input logic [15:0] rp, input bit sync);
    cmd_t c;
    c.fn = fn;
    c.id = id;
    c.sd = sd;
    c.ed = ed;
    c.rp = rp;
    c.sync = sync;
    cmd_q = {cmd_q, c};
  endtask

  task automatic push_note(input status_t st, input logic [7:0] id, input logic lst);
    note_t r;
    r.st = st;
    r.id = id;
    r.last = lst;
    want_q = {want_q, r};
  endtask

  task automatic table_step(input cmd_t c);
    bit        done [SLOTS];
    bit [31:0] age;
    bit [31:0] best_age;
    int        best;
    int        hits;
    int        s;
    int        i;
    case (c.fn)
      FN_TICK: begin
        tick_now = tick_now + 32'd1;
        for (i = 0; i < SLOTS; i++) done[i] = 1'b0;
        hits = 0;
        while (hits < MAX_FIRES) begin
          best = -1;
          best_age = '0;
          for (i = 0; i < SLOTS; i++) begin
            if (slot_on[i] && !done[i]) begin
              age = (slot_due[i] - tick_now) ^ DUE_BIAS;
              if (age >= DUE_BIAS && (best < 0 || age < best_age ||
                  (age == best_age && slot_id[i] < slot_id[best]))) begin
                best = i;
                best_age = age;
              end
            end
          end
          if (best < 0) break;
          done[best] = 1'b1;
          push_note(ST_FIRED, slot_id[best], 1'b0);
          hits++;
          if (slot_per[best] != 0) slot_due[best] = slot_due[best] + slot_per[best];
          else slot_on[best] = 1'b0;
        end
        if (hits > 0) want_q[want_q.size() - 1].last = 1'b1;
      end
      FN_ADD: begin
        s = -1;
        for (i = 0; i < SLOTS; i++)
          if (s < 0 && slot_on[i] && slot_id[i] == c.id) s = i;
        for (i = 0; i < SLOTS; i++)
          if (s < 0 && !slot_on[i]) s = i;
        if (s < 0) begin
          push_note(ST_FULL, c.id, 1'b1);
        end else begin
          slot_on[s] = 1'b1;
          slot_id[s] = c.id;
          slot_due[s] = tick_now + c.sd + c.ed;
          slot_per[s] = c.rp;
          push_note(ST_DONE, c.id, 1'b1);
        end
      end
      FN_DEL: begin
        for (i = 0; i < SLOTS; i++)
          if (slot_on[i] && slot_id[i] == c.id) slot_on[i] = 1'b0;
        push_note(ST_DONE, c.id, 1'b1);
      end
      default: begin
        for (i = 0; i < SLOTS; i++) slot_on[i] = 1'b0;
        push_note(ST_DONE, 8'd0, 1'b1);
      end
    endcase
  endtask

  // sender
  always @(negedge clk) begin
    cmd_t it;
    logic v;
    if (!rst) begin
      v = in_valid && !in_taken;
      if (!v) begin
        if (tx_wait > 0) begin
          tx_wait <= tx_wait - 1;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].sync && want_q.size() > 0)) begin
          it = cmd_q.pop_front();
          func <= it.fn;
          timer_id <= it.id;
          start_delay <= it.sd;
          expire_delay <= it.ed;
          reload_period <= it.rp;
          v = 1'b1;
          tx_wait <= ((acc_n / 40) % 3 == 1) ? 0 : $urandom_range(0, 4);
        end
      end
      in_valid <= v;
    end
  end

  // receiver, with two long hold-offs to back up the block
  always @(negedge clk) begin
    int n;
    if (!rst) begin
      n = rx_wait;
      if (out_taken) begin
        if (got_n == 30 || got_n == 150) n = HOLD_CYCLES;
        else if ((got_n / 50) % 3 == 2) n = 0;
        else n = $urandom_range(0, 4);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        rx_wait <= n - 1;
      end else begin
        out_ready <= 1'b1;
        rx_wait <= 0;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    note_t r;
    in_taken <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        table_step('{fn: func_t'(func), id: timer_id, sd: start_delay,
                     ed: expire_delay, rp: reload_period, sync: 1'b0});
        acc_n++;
      end
      if (out_valid && out_ready) begin
        got_n++;
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result: status=%0d id=%0d last=%0d",
                   $time, status, fired_id, last);
          fails++;
        end else begin
          r = want_q.pop_front();
          if (status !== r.st || fired_id !== r.id || last !== r.last) begin
            $display({"%0t: mismatch: expected status=%0d id=%0d last=%0d, ",
                      "got status=%0d id=%0d last=%0d"},
                     $time, r.st, r.id, r.last, status, fired_id, last);
            fails++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int         k;
    int         sel;
    logic [7:0] id;
    logic [15:0] sd;
    logic [15:0] ed;
    logic [15:0] rp;

    queue_cmd(FN_DEL_ALL, 8'hff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    queue_cmd(FN_TICK, 8'h5a, 16'h1234, 16'h00ff, 16'hffff, 1'b0);
    // tie on expiry: higher id sits in the lower slot
    queue_cmd(FN_ADD, 8'd200, 16'd0, 16'd0, 16'd0, 1'b0);
    queue_cmd(FN_ADD, 8'd5, 16'd0, 16'd0, 16'd0, 1'b0);
    queue_cmd(FN_ADD, 8'd255, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    queue_cmd(FN_ADD, 8'd7, 16'd0, 16'd1, 16'd1, 1'b0);
    queue_cmd(FN_ADD, 8'd5, 16'd0, 16'd0, 16'd3, 1'b0);
    queue_cmd(FN_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    queue_cmd(FN_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    queue_cmd(FN_DEL, 8'd200, 16'hffff, 16'd0, 16'hffff, 1'b0);
    queue_cmd(FN_DEL, 8'd7, 16'd0, 16'hffff, 16'd0, 1'b0);
    queue_cmd(FN_DEL_ALL, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    for (k = 0; k < SLOTS; k++)
      queue_cmd(FN_ADD, 8'(16 + k), 16'd0, 16'd0, 16'(k % 2), 1'b0);
    queue_cmd(FN_ADD, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    queue_cmd(FN_ADD, 8'd16, 16'd0, 16'd0, 16'd0, 1'b0);
    queue_cmd(FN_TICK, 8'hff, 16'd0, 16'd0, 16'd0, 1'b0);
    queue_cmd(FN_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0);

    for (k = 0; k < 350; k++) begin
      sel = $urandom_range(0, 99);
      id = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
      if ($urandom_range(0, 7) == 0) begin
        sd = 16'($urandom);
        ed = 16'($urandom);
      end else begin
        sd = 16'($urandom_range(0, 3));
        ed = 16'($urandom_range(0, 6));
      end
      rp = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      if (sel < 3)
        queue_cmd(FN_DEL_ALL, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  k == 175);
      else if (sel < 15)
        queue_cmd(FN_DEL, id, 16'($urandom), 16'($urandom), 16'($urandom), k == 175);
      else if (sel < 50)
        queue_cmd(FN_ADD, id, sd, ed, rp, k == 0 || k == 175);
      else
        queue_cmd(FN_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  k == 175);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (cmd_q.size() > 0 || in_valid || want_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fails == 0 && want_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ptt_pkg.sv
rtl/ptt_mem.sv
rtl/ptt_scan.sv
rtl/periodic_timer_table.sv
dv/periodic_timer_table_tb.sv
